// ===== rtl/q2e_pkg.sv =====
package q2e_pkg;

  localparam int IDXW  = 5;
  localparam int QW    = 16;
  localparam int ANGW  = 15;
  localparam int PANGW = 14;
  localparam int SUMW  = 34;
  localparam int TRMW  = 36;
  localparam int MOPW  = 29;
  localparam int PRDW  = 58;
  localparam int SQW   = 58;
  localparam int CORW  = 44;
  localparam int ACCW  = 26;
  localparam int ATW   = 22;
  localparam int OFFW  = 3 * ANGW;

  localparam logic signed [TRMW-1:0] ONE_Q28      = 36'sd268435456;
  localparam logic signed [CORW-1:0] NORM_LIM     = 44'sh10000000000;
  localparam logic signed [ACCW-1:0] QUARTER_ACC  = 26'sd5898240;
  localparam logic signed [ACCW-1:0] ROUND_HALF   = 26'sd512;
  localparam logic signed [15:0]     HALF_TURN    = 16'sd11520;
  localparam logic signed [15:0]     QUARTER_TURN = 16'sd5760;
  localparam logic signed [15:0]     FULL_TURN    = 16'sd23040;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_PSQ,
    S_SQRT,
    S_CLOAD,
    S_NORM,
    S_QUAD,
    S_ITER,
    S_ROUND,
    S_REL
  } st_t;

  typedef enum logic [1:0] {
    SEL_ROLL,
    SEL_PITCH,
    SEL_YAW
  } sel_t;

  function automatic logic [ATW-1:0] atan_lut(input logic [3:0] i);
    logic [ATW-1:0] v;
    case (i)
      4'd0:  v = 22'd2949120;
      4'd1:  v = 22'd1740967;
      4'd2:  v = 22'd919879;
      4'd3:  v = 22'd466945;
      4'd4:  v = 22'd234379;
      4'd5:  v = 22'd117304;
      4'd6:  v = 22'd58666;
      4'd7:  v = 22'd29335;
      4'd8:  v = 22'd14668;
      4'd9:  v = 22'd7334;
      4'd10: v = 22'd3667;
      4'd11: v = 22'd1833;
      4'd12: v = 22'd917;
      4'd13: v = 22'd458;
      4'd14: v = 22'd229;
      4'd15: v = 22'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/q2e_ram.sv =====
module q2e_ram #(
  parameter int WIDTH = 45,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/quaternion_to_euler_centered.sv =====
// channel  | handshake             | words
// in_      | in_valid / in_stall   | controller_index, center_now, quat_w/x/y/z
// out_     | out_valid / out_stall | controller_echo, yaw/pitch/roll abs and rel
//
// one word at a time; a multiply step per product, then square root steps unless
// pitch saturates, then one atan2 pass each for roll, pitch (unless saturated)
// and yaw: normalize steps, one per doubling, a quadrant step, rotation steps
// and a rounding step; the multiplier, square root step and rotation unit are shared
// reset clears the offset valid bits, so all offsets read as zero
// a finished word waits in the output register while the next word is accepted
module quaternion_to_euler_centered
  import q2e_pkg::*;
#(
  parameter int NUM_CONTROLLERS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [IDXW-1:0]         in_controller_index,
  input  logic                    in_center_now,
  input  logic signed [QW-1:0]    in_quat_w,
  input  logic signed [QW-1:0]    in_quat_x,
  input  logic signed [QW-1:0]    in_quat_y,
  input  logic signed [QW-1:0]    in_quat_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDXW-1:0]         out_controller_echo,
  output logic signed [ANGW-1:0]  out_yaw_abs,
  output logic signed [PANGW-1:0] out_pitch_abs,
  output logic signed [ANGW-1:0]  out_roll_abs,
  output logic signed [ANGW-1:0]  out_yaw_rel,
  output logic signed [ANGW-1:0]  out_pitch_rel,
  output logic signed [ANGW-1:0]  out_roll_rel
);

  localparam int AW = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
  localparam int XW = (AW > IDXW) ? AW : IDXW;

  st_t st_r, st_nxt;
  sel_t sel_r, sel_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic ctr_r, ctr_nxt;
  logic signed [QW-1:0] qw_r, qw_nxt, qx_r, qx_nxt, qy_r, qy_nxt, qz_r, qz_nxt;
  logic signed [SUMW-1:0] srs_r, srs_nxt, crs_r, crs_nxt, sps_r, sps_nxt;
  logic signed [SUMW-1:0] sys_r, sys_nxt, cys_r, cys_nxt;
  logic psat_r, psat_nxt;
  logic [SQW-1:0] n_r, n_nxt, res_r, res_nxt;
  logic signed [CORW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic signed [ANGW-1:0] roll_r, roll_nxt, pitch_r, pitch_nxt, yaw_r, yaw_nxt;
  logic [NUM_CONTROLLERS-1:0] vld_r, vld_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [IDXW-1:0] o_idx_r, o_idx_nxt;
  logic signed [ANGW-1:0] o_yaw_r, o_yaw_nxt, o_roll_r, o_roll_nxt;
  logic signed [PANGW-1:0] o_pitch_r, o_pitch_nxt;
  logic signed [ANGW-1:0] o_yawr_r, o_yawr_nxt, o_pitchr_r, o_pitchr_nxt;
  logic signed [ANGW-1:0] o_rollr_r, o_rollr_nxt;

  logic signed [TRMW-1:0] sr_t, cr_t, sp_t, sy_t, cy_t;
  logic signed [MOPW-1:0] mul_a, mul_b;
  logic signed [PRDW-1:0] prod;
  logic [SQW-1:0] prod_u, bitv, sqsum;
  logic signed [SUMW-1:0] prod_s;
  logic signed [CORW-1:0] dx, dy, ly, lx;
  logic signed [ACCW-1:0] lut_s, rsum, rsh;
  logic signed [15:0] lim, ang16;
  logic signed [ANGW-1:0] ang;
  logic [XW-1:0] idx_x, in_idx_x;
  logic [AW-1:0] addr, in_addr;
  logic have;
  logic ram_we, ram_re;
  logic [OFFW-1:0] ram_wdata, ram_rdata, off;
  logic signed [15:0] dyaw, dpitch, droll;

  assign sr_t = TRMW'(srs_r) <<< 1;
  assign cr_t = ONE_Q28 - (TRMW'(crs_r) <<< 1);
  assign sp_t = TRMW'(sps_r) <<< 1;
  assign sy_t = TRMW'(sys_r) <<< 1;
  assign cy_t = ONE_Q28 - (TRMW'(cys_r) <<< 1);

  assign prod   = PRDW'(mul_a) * PRDW'(mul_b);
  assign prod_u = prod;
  assign prod_s = SUMW'(prod);
  assign bitv   = SQW'(1) << {cnt_r, 1'b0};
  assign sqsum  = res_r + bitv;
  assign dx     = y_r >>> cnt_r[3:0];
  assign dy     = x_r >>> cnt_r[3:0];
  assign lut_s  = $signed(ACCW'(atan_lut(cnt_r[3:0])));
  assign rsum   = acc_r + ROUND_HALF;
  assign rsh    = rsum >>> 10;
  assign lim    = (sel_r == SEL_PITCH) ? QUARTER_TURN : HALF_TURN;
  assign ang16  = (rsh > ACCW'(lim)) ? lim : (rsh < -ACCW'(lim)) ? -lim : 16'(rsh);
  assign ang    = ANGW'(ang16);

  assign idx_x    = XW'(idx_r);
  assign in_idx_x = XW'(in_controller_index);
  assign addr     = idx_x[AW-1:0];
  assign in_addr  = in_idx_x[AW-1:0];
  assign have     = {1'b0, idx_x} < (XW + 1)'(NUM_CONTROLLERS);

  assign ram_re    = in_valid && !in_stall;
  assign ram_wdata = {yaw_r, pitch_r, roll_r};
  assign off = (have && ctr_r) ? ram_wdata :
               (have && vld_r[addr]) ? ram_rdata : '0;
  assign dyaw   = 16'(yaw_r) - 16'($signed(off[3*ANGW-1:2*ANGW]));
  assign dpitch = 16'(pitch_r) - 16'($signed(off[2*ANGW-1:ANGW]));
  assign droll  = 16'(roll_r) - 16'($signed(off[ANGW-1:0]));

  function automatic logic signed [ANGW-1:0] wrap(input logic signed [15:0] d);
    logic signed [15:0] r;
    r = d;
    if (d < -HALF_TURN) begin
      r = d + FULL_TURN;
    end else if (d > HALF_TURN) begin
      r = d - FULL_TURN;
    end
    return ANGW'(r);
  endfunction

  q2e_ram #(
    .WIDTH (OFFW),
    .DEPTH (NUM_CONTROLLERS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cnt_r[3:0])
      4'd0: begin mul_a = MOPW'(qw_r); mul_b = MOPW'(qx_r); end
      4'd1: begin mul_a = MOPW'(qy_r); mul_b = MOPW'(qz_r); end
      4'd2: begin mul_a = MOPW'(qx_r); mul_b = MOPW'(qx_r); end
      4'd3: begin mul_a = MOPW'(qy_r); mul_b = MOPW'(qy_r); end
      4'd4: begin mul_a = MOPW'(qw_r); mul_b = MOPW'(qy_r); end
      4'd5: begin mul_a = MOPW'(qz_r); mul_b = MOPW'(qx_r); end
      4'd6: begin mul_a = MOPW'(qw_r); mul_b = MOPW'(qz_r); end
      4'd7: begin mul_a = MOPW'(qx_r); mul_b = MOPW'(qy_r); end
      4'd8: begin mul_a = MOPW'(qz_r); mul_b = MOPW'(qz_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    if (st_r == S_PSQ) begin
      mul_a = MOPW'(sp_t);
      mul_b = MOPW'(sp_t);
    end
  end

  always_comb begin
    ly = '0;
    lx = '0;
    case (sel_r)
      SEL_ROLL:  begin ly = CORW'(sr_t); lx = CORW'(cr_t); end
      SEL_PITCH: begin ly = CORW'(sp_t); lx = CORW'(res_r[MOPW-1:0]); end
      SEL_YAW:   begin ly = CORW'(sy_t); lx = CORW'(cy_t); end
      default:   begin ly = '0; lx = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    ctr_r      <= ctr_nxt;
    qw_r       <= qw_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    qz_r       <= qz_nxt;
    srs_r      <= srs_nxt;
    crs_r      <= crs_nxt;
    sps_r      <= sps_nxt;
    sys_r      <= sys_nxt;
    cys_r      <= cys_nxt;
    psat_r     <= psat_nxt;
    n_r        <= n_nxt;
    res_r      <= res_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    acc_r      <= acc_nxt;
    roll_r     <= roll_nxt;
    pitch_r    <= pitch_nxt;
    yaw_r      <= yaw_nxt;
    o_idx_r    <= o_idx_nxt;
    o_yaw_r    <= o_yaw_nxt;
    o_pitch_r  <= o_pitch_nxt;
    o_roll_r   <= o_roll_nxt;
    o_yawr_r   <= o_yawr_nxt;
    o_pitchr_r <= o_pitchr_nxt;
    o_rollr_r  <= o_rollr_nxt;
  end

  always_comb begin
    logic store;
    logic signed [ANGW-1:0] sval;
    store         = 1'b0;
    sval          = '0;
    st_nxt        = st_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    ctr_nxt       = ctr_r;
    qw_nxt        = qw_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    qz_nxt        = qz_r;
    srs_nxt       = srs_r;
    crs_nxt       = crs_r;
    sps_nxt       = sps_r;
    sys_nxt       = sys_r;
    cys_nxt       = cys_r;
    psat_nxt      = psat_r;
    n_nxt         = n_r;
    res_nxt       = res_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    acc_nxt       = acc_r;
    roll_nxt      = roll_r;
    pitch_nxt     = pitch_r;
    yaw_nxt       = yaw_r;
    vld_nxt       = vld_r;
    ram_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    o_idx_nxt     = o_idx_r;
    o_yaw_nxt     = o_yaw_r;
    o_pitch_nxt   = o_pitch_r;
    o_roll_nxt    = o_roll_r;
    o_yawr_nxt    = o_yawr_r;
    o_pitchr_nxt  = o_pitchr_r;
    o_rollr_nxt   = o_rollr_r;
    in_stall      = (st_r != S_IDLE);

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt = in_controller_index;
          ctr_nxt = in_center_now;
          qw_nxt  = in_quat_w;
          qx_nxt  = in_quat_x;
          qy_nxt  = in_quat_y;
          qz_nxt  = in_quat_z;
          cnt_nxt = '0;
          st_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        case (cnt_r[3:0])
          4'd0: srs_nxt = prod_s;
          4'd1: srs_nxt = srs_r + prod_s;
          4'd2: crs_nxt = prod_s;
          4'd3: begin crs_nxt = crs_r + prod_s; cys_nxt = prod_s; end
          4'd4: sps_nxt = prod_s;
          4'd5: sps_nxt = sps_r - prod_s;
          4'd6: sys_nxt = prod_s;
          4'd7: sys_nxt = sys_r + prod_s;
          4'd8: cys_nxt = cys_r + prod_s;
          default: cys_nxt = cys_r;
        endcase
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd8) begin
          st_nxt = S_PSQ;
        end
      end
      S_PSQ: begin
        psat_nxt = (sp_t >= ONE_Q28) || (sp_t <= -ONE_Q28);
        sel_nxt  = SEL_ROLL;
        if (psat_nxt) begin
          pitch_nxt = (sp_t < 0) ? -ANGW'(QUARTER_TURN) : ANGW'(QUARTER_TURN);
          st_nxt    = S_CLOAD;
        end else begin
          n_nxt   = (SQW'(1) << 56) - prod_u;
          res_nxt = '0;
          cnt_nxt = 5'd28;
          st_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (n_r >= sqsum) begin
          n_nxt   = n_r - sqsum;
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          st_nxt = S_CLOAD;
        end
      end
      S_CLOAD: begin
        x_nxt = lx;
        y_nxt = ly;
        if (lx == '0 && ly == '0) begin
          store = 1'b1;
          sval  = '0;
        end else begin
          st_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (x_r < NORM_LIM && x_r > -NORM_LIM && y_r < NORM_LIM && y_r > -NORM_LIM) begin
          x_nxt = x_r <<< 1;
          y_nxt = y_r <<< 1;
        end else begin
          st_nxt = S_QUAD;
        end
      end
      S_QUAD: begin
        acc_nxt = '0;
        if (x_r < 0) begin
          if (y_r >= 0) begin
            x_nxt   = y_r;
            y_nxt   = -x_r;
            acc_nxt = QUARTER_ACC;
          end else begin
            x_nxt   = -y_r;
            y_nxt   = x_r;
            acc_nxt = -QUARTER_ACC;
          end
        end
        cnt_nxt = '0;
        st_nxt  = S_ITER;
      end
      S_ITER: begin
        if (y_r > 0) begin
          x_nxt   = x_r + dx;
          y_nxt   = y_r - dy;
          acc_nxt = acc_r + lut_s;
        end else begin
          x_nxt   = x_r - dx;
          y_nxt   = y_r + dy;
          acc_nxt = acc_r - lut_s;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          st_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        store = 1'b1;
        sval  = ang;
      end
      S_REL: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          o_idx_nxt     = idx_r;
          o_yaw_nxt     = yaw_r;
          o_pitch_nxt   = PANGW'(pitch_r);
          o_roll_nxt    = roll_r;
          o_yawr_nxt    = wrap(dyaw);
          o_pitchr_nxt  = wrap(dpitch);
          o_rollr_nxt   = wrap(droll);
          if (have && ctr_r) begin
            ram_we        = 1'b1;
            vld_nxt[addr] = 1'b1;
          end
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (store) begin
      st_nxt = S_CLOAD;
      case (sel_r)
        SEL_ROLL: begin
          roll_nxt = sval;
          sel_nxt  = psat_r ? SEL_YAW : SEL_PITCH;
        end
        SEL_PITCH: begin
          pitch_nxt = sval;
          sel_nxt   = SEL_YAW;
        end
        SEL_YAW: begin
          yaw_nxt = sval;
          st_nxt  = S_REL;
        end
        default: st_nxt = S_REL;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_controller_echo = o_idx_r;
  assign out_yaw_abs         = o_yaw_r;
  assign out_pitch_abs       = o_pitch_r;
  assign out_roll_abs        = o_roll_r;
  assign out_yaw_rel         = o_yawr_r;
  assign out_pitch_rel       = o_pitchr_r;
  assign out_roll_rel        = o_rollr_r;

  a_we_in_rel: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (st_r == S_REL && ctr_r))
    else $error("offset write outside result stage");

  a_rel_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_REL && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("result not presented");

  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pitch_abs <= 14'sd5760 && out_pitch_abs >= -14'sd5760))
    else $error("pitch out of range");

  a_sqrt_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SQRT) |-> !psat_r)
    else $error("square root on saturated pitch");

endmodule
